@@ design/assert_macros.svh @@
// Assertion macros used by the word generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/mtw_pkg.sv @@
package mtw_pkg;

    // Widths of the generator word and the state index, state size and middle offset.
    localparam int WORD_W  = 32;
    localparam int STATE_WORDS   = 624;
    localparam int MIDDLE_OFFSET = 397;
    localparam int INDEX_W = $clog2(STATE_WORDS);

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [INDEX_W-1:0] t_index;

    // Generator constants.
    localparam t_word TWIST_MATRIX = 32'h9908_b0df;
    localparam t_word TEMPER_B     = 32'h9d2c_5680;
    localparam t_word TEMPER_C     = 32'hefc6_0000;
    localparam t_word INIT_MULT    = 32'd1812433253;
    localparam t_word SEED_RESET   = 32'd19650218;
    localparam t_word UPPER_BIT    = 32'h8000_0000;
    localparam t_word LOWER_BITS   = 32'h7fff_ffff;

    localparam t_index LAST_INDEX = INDEX_W'(STATE_WORDS - 1);

    // Adds a constant offset below STATE_WORDS to an index, wrapping once.
    function automatic t_index wrap_add(t_index idx, t_index offset);
        logic [INDEX_W:0] sum;
        sum = {1'b0, idx} + {1'b0, offset};
        if (sum >= (INDEX_W+1)'(STATE_WORDS)) begin
            sum = sum - (INDEX_W+1)'(STATE_WORDS);
        end
        return sum[INDEX_W-1:0];
    endfunction

    // One twist step: upper bit of word k, lower bits of word k+1, middle word.
    function automatic t_word twist(t_word w_k, t_word w_next, t_word w_mid);
        t_word x;
        t_word xa;
        x  = (w_k & UPPER_BIT) | (w_next & LOWER_BITS);
        xa = x >> 1;
        if (x[0]) begin
            xa = xa ^ TWIST_MATRIX;
        end
        return w_mid ^ xa;
    endfunction

    // Output tempering.
    function automatic t_word temper(t_word x);
        t_word y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

@@ design/mtw_draw_if.sv @@
interface mtw_draw_if
    import mtw_pkg::*;
();
    logic valid;
    logic ready;
    logic draw_request;

    modport source (output valid, output draw_request, input ready);
    modport sink (input valid, input draw_request, output ready);
endinterface

@@ design/mtw_word_if.sv @@
interface mtw_word_if
    import mtw_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word random_word;

    modport source (output valid, output random_word, input ready);
    modport sink (input valid, input random_word, output ready);
endinterface

@@ design/mt19937_word_generator.sv @@
// MT19937 word generator: each transfer on i_draw with draw_request set yields one tempered
// 32-bit word on o_word; a transfer with draw_request clear is taken and changes nothing.
// Draws are taken one per cycle while no refill runs and the output register can take a word;
// each result is registered and shows in the cycle after its draw. The 624-word state sits in
// one memory with a write port and two registered read ports that prefetch words k+1 and k+397;
// word k is held in a register. After reset, and after every seed write on i_cfg_we/i_cfg_wdata,
// the state is refilled from the seed at one word per cycle (one multiply each), so i_draw.ready
// stays low until all 624 words are written; the seed reset value is 19650218.
module mt19937_word_generator
    import mtw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_word            i_cfg_wdata,
    mtw_draw_if.sink         i_draw,
    mtw_word_if.source       o_word
);

`include "assert_macros.svh"

    // State memory and its registered read ports.
    t_word  r_mem [STATE_WORDS];
    t_word  r_rd_next;
    t_word  r_rd_mid;

    // Control and working registers.
    logic   r_filling;
    t_index r_fill_idx;
    t_word  r_fill_word;
    t_index r_index;
    t_word  r_word_k;
    logic   r_out_valid;
    t_word  r_out_word;

    logic   draw;
    t_index n_index;
    t_index rd_next_addr;
    t_index rd_mid_addr;
    t_word  twisted;
    t_word  fill_prod;
    t_index fill_idx_inc;
    t_word  n_fill_word;
    logic   mem_we;
    t_index mem_waddr;
    t_word  mem_wdata;

    // Input side is open while no refill runs and the output register can take a word.
    assign i_draw.ready = !r_filling && (!r_out_valid || o_word.ready);
    assign draw         = i_draw.valid && i_draw.ready && i_draw.draw_request;

    // Twist from the held word k and the two prefetched words.
    assign twisted = twist(r_word_k, r_rd_next, r_rd_mid);

    // Index after this cycle; the read ports always look ahead of it.
    always_comb begin
        n_index = r_index;
        if (i_cfg_we) begin
            n_index = '0;
        end else if (draw) begin
            n_index = (r_index == LAST_INDEX) ? '0 : r_index + 1'b1;
        end
    end

    assign rd_next_addr = wrap_add(n_index, INDEX_W'(1));
    assign rd_mid_addr  = wrap_add(n_index, INDEX_W'(MIDDLE_OFFSET));

    // Seed recurrence: one multiply per cycle, registered before the next.
    assign fill_idx_inc = r_fill_idx + 1'b1;
    assign fill_prod    = INIT_MULT * (r_fill_word ^ (r_fill_word >> 30));
    assign n_fill_word  = fill_prod + {{(WORD_W-INDEX_W){1'b0}}, fill_idx_inc};

    // Memory write selection: refill words or the freshly twisted word.
    assign mem_we    = r_filling || draw;
    assign mem_waddr = r_filling ? r_fill_idx : r_index;
    assign mem_wdata = r_filling ? r_fill_word : twisted;

    // State memory with one write and two registered reads.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_next <= r_mem[rd_next_addr];
        r_rd_mid  <= r_mem[rd_mid_addr];
    end

    // Refill sequencer, index and held word k.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filling   <= 1'b1;
            r_fill_idx  <= '0;
            r_fill_word <= SEED_RESET;
            r_index     <= '0;
            r_word_k    <= SEED_RESET;
        end else if (i_cfg_we) begin
            r_filling   <= 1'b1;
            r_fill_idx  <= '0;
            r_fill_word <= i_cfg_wdata;
            r_index     <= '0;
            r_word_k    <= i_cfg_wdata;
        end else if (r_filling) begin
            r_fill_idx  <= fill_idx_inc;
            r_fill_word <= n_fill_word;
            if (r_fill_idx == LAST_INDEX) begin
                r_filling <= 1'b0;
            end
        end else if (draw) begin
            r_index  <= n_index;
            r_word_k <= r_rd_next;
        end
    end

    // Result register: loads on a draw, empties on a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (draw) begin
            r_out_valid <= 1'b1;
        end else if (o_word.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (draw) begin
            r_out_word <= temper(twisted);
        end
    end

    assign o_word.valid       = r_out_valid;
    assign o_word.random_word = r_out_word;

    // Index stays inside the state array.
    `ASSERT_NEVER(a_index_range, i_clk, i_rst_n, r_index > LAST_INDEX, "word index out of range")
    // A draw always leaves a word in the result register.
    `ASSERT_CLK(a_draw_result, i_clk, i_rst_n, draw |=> r_out_valid, "draw lost its result")
    // A refill ends with the index at the start of the array.
    `ASSERT_CLK(a_fill_end, i_clk, i_rst_n, $fell(r_filling) |-> (r_index == '0),
        "refill ended with nonzero index")
    // A draw at the last word wraps the index to zero.
    `ASSERT_CLK(a_wrap, i_clk, i_rst_n,
        (draw && !i_cfg_we && (r_index == LAST_INDEX)) |=> (r_index == '0),
        "index did not wrap")

endmodule
